// File: src/imm_pkg.sv
// Shared types and sizes of the integer matrix multiply block.
`default_nettype none
package imm_pkg;

   localparam int MAX_DIM     = 8;
   localparam int DATA_WIDTH  = 16;
   localparam int CFG_WIDTH   = 4;
   localparam int PRODUCT_W   = 36;
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SQ_W        = 2 * DIM_W;
   localparam int MUL_W       = 2 * DATA_WIDTH;
   localparam int ACC_W       = MUL_W + IDX_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_WIDTH-1:0] DIM_RESET = CFG_WIDTH'(8);

   localparam logic OP_LOAD_B   = 1'b0;
   localparam logic OP_STREAM_A = 1'b1;

   typedef struct packed {
      logic                         op;
      logic signed [DATA_WIDTH-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [PRODUCT_W-1:0] product_value;
      logic [IDX_W-1:0]            row_index;
      logic [IDX_W-1:0]            col_index;
      logic                        last;
   } rsp_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic                         is_a;
      logic signed [DATA_WIDTH-1:0] value;
      logic [ADDR_W-1:0]            addr;
      logic                         row_end;
      logic [IDX_W-1:0]             row;
   } job_type;

endpackage
`default_nettype wire

// File: src/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/imm_queue.sv
// Short job queue between the front and the back.
`default_nettype none
module imm_queue
   import imm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         full,
   output logic         empty
);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// File: src/imm_front.sv
// Front end: takes input beats and the dim register, tracks load and row positions.
`default_nettype none
module imm_front
   import imm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CFG_WIDTH-1:0] csr_data,
   input  wire logic                 idle,
   input  wire logic                 q_full,
   output logic                      q_push,
   output job_type                   q_job,
   output logic                      cfg_clear,
   output logic [DIM_W-1:0]          dim_active
);

   logic [CFG_WIDTH-1:0] dim_ff, dim_in;
   logic [ADDR_W-1:0]    b_pos_ff, b_pos_in;
   logic [IDX_W-1:0]     a_col_ff, a_col_in;
   logic [ADDR_W-1:0]    a_base_ff, a_base_in;
   logic [IDX_W-1:0]     a_row_ff, a_row_in;
   logic                 accept;
   logic                 row_end;
   logic [SQ_W-1:0]      dim_sq;
   logic [SQ_W-1:0]      b_pos_next;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_WIDTH-1:0] v);
      logic [DIM_W-1:0] d;
      if (v == '0) begin
         d = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(v);
      end
      return d;
   endfunction

   assign dim_active = clamp_dim(dim_ff);
   assign dim_sq     = SQ_W'(dim_active) * SQ_W'(dim_active);
   assign b_pos_next = SQ_W'(b_pos_ff) + SQ_W'(1);
   assign row_end    = (DIM_W'(a_col_ff) + DIM_W'(1)) == dim_active;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign csr_ready = idle;
   assign cfg_clear = csr_valid && csr_ready;
   assign q_push    = accept;

   always_comb begin
      q_job.is_a    = (req_payload.op == OP_STREAM_A);
      q_job.value   = req_payload.element_value;
      q_job.addr    = q_job.is_a ? a_base_ff : b_pos_ff;
      q_job.row_end = row_end;
      q_job.row     = a_row_ff;
   end

   always_comb begin
      dim_in    = dim_ff;
      b_pos_in  = b_pos_ff;
      a_col_in  = a_col_ff;
      a_base_in = a_base_ff;
      a_row_in  = a_row_ff;
      if (cfg_clear) begin
         dim_in    = csr_data;
         b_pos_in  = '0;
         a_col_in  = '0;
         a_base_in = '0;
         a_row_in  = '0;
      end else if (accept) begin
         if (req_payload.op == OP_LOAD_B) begin
            // wrap after dim*dim elements
            b_pos_in = (b_pos_next >= dim_sq) ? '0 : b_pos_next[ADDR_W-1:0];
         end else if (row_end) begin
            a_col_in  = '0;
            a_base_in = '0;
            a_row_in  = ((DIM_W'(a_row_ff) + DIM_W'(1)) == dim_active) ? '0
                                                                         : a_row_ff + 1'b1;
         end else begin
            a_col_in  = a_col_ff + 1'b1;
            a_base_in = a_base_ff + ADDR_W'(dim_active);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_RESET;
         b_pos_ff  <= '0;
         a_col_ff  <= '0;
         a_base_ff <= '0;
         a_row_ff  <= '0;
      end else begin
         dim_ff    <= dim_in;
         b_pos_ff  <= b_pos_in;
         a_col_ff  <= a_col_in;
         a_base_ff <= a_base_in;
         a_row_ff  <= a_row_in;
      end
   end

endmodule
`default_nettype wire

// File: src/imm_back.sv
// Back end: B store writes, column-serial multiply-accumulate and row emission.
`default_nettype none
module imm_back
   import imm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cfg_clear,
   input  wire logic [DIM_W-1:0] dim_active,
   input  wire job_type          q_job,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  busy,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic signed [ACC_W-1:0]      acc_ff [MAX_DIM];
   logic signed [ACC_W-1:0]      acc_in [MAX_DIM];
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic [DIM_W-1:0]             issue_j_ff, issue_j_in;
   logic [DIM_W-1:0]             emit_j_ff, emit_j_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]             s1_j_ff, s2_j_ff;
   logic signed [MUL_W-1:0]      prod_ff;
   logic signed [DATA_WIDTH-1:0] a_val_ff;
   logic [ADDR_W-1:0]            base_ff;
   logic                         row_end_ff;
   logic [IDX_W-1:0]             row_ff;
   logic                         load_job;
   logic                         issue_on;
   logic                         out_free;
   logic                         emit_last;
   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic [DATA_WIDTH-1:0]        ram_rd_data;

   assign q_pop       = (state_ff == ST_IDLE) && !q_empty;
   assign load_job    = q_pop && q_job.is_a;
   assign ram_wr_en   = q_pop && !q_job.is_a;
   assign issue_on    = (state_ff == ST_MAC) && (issue_j_ff != dim_active);
   assign ram_rd_addr = base_ff + ADDR_W'(issue_j_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit_last   = (emit_j_ff + DIM_W'(1)) == dim_active;
   assign busy        = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   imm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (q_job.addr),
      .wr_data (q_job.value),
      .rd_en   (issue_on),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      issue_j_in   = issue_j_ff;
      emit_j_in    = emit_j_ff;
      s1_valid_in  = issue_on;
      s2_valid_in  = s1_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (s2_valid_ff) begin
         acc_in[s2_j_ff] = acc_ff[s2_j_ff] + {{IDX_W{prod_ff[MUL_W-1]}}, prod_ff};
      end

      case (state_ff)
         ST_IDLE: begin
            if (load_job) begin
               issue_j_in = '0;
               state_in   = ST_MAC;
            end
         end
         ST_MAC: begin
            if (issue_on) begin
               issue_j_in = issue_j_ff + 1'b1;
            end else if (!s1_valid_ff && !s2_valid_ff) begin
               emit_j_in = '0;
               state_in  = row_end_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.product_value  = {{(PRODUCT_W - ACC_W){acc_ff[0][ACC_W-1]}}, acc_ff[0]};
               rsp_in.row_index      = row_ff;
               rsp_in.col_index      = emit_j_ff[IDX_W-1:0];
               rsp_in.last           = emit_last;
               // shift down: entries at and above dim are always zero
               for (int i = 0; i < MAX_DIM - 1; i++) begin
                  acc_in[i] = acc_ff[i + 1];
               end
               acc_in[MAX_DIM-1] = '0;
               emit_j_in         = emit_j_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_clear) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            acc_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         issue_j_ff   <= '0;
         emit_j_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_DIM; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_j_ff   <= issue_j_in;
         emit_j_ff    <= emit_j_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         acc_ff       <= acc_in;
      end
      rsp_ff <= rsp_in;
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      s1_j_ff <= issue_j_ff[IDX_W-1:0];
      s2_j_ff <= s1_j_ff;
      prod_ff <= a_val_ff * $signed(ram_rd_data);
      if (load_job) begin
         a_val_ff   <= q_job.value;
         base_ff    <= q_job.addr;
         row_end_ff <= q_job.row_end;
         row_ff     <= q_job.row;
      end
   end

endmodule
`default_nettype wire

// File: src/integer_matrix_multiply.sv
// Top level of the integer matrix multiply block.
//
// Load B first: req beats with op = 0 carry B elements in row-major order
// and land in a 64-entry store; the load position wraps after dim*dim beats.
// Then stream A with op = 1, row-major. Each A beat is multiplied against one
// B row, one column per cycle through a single multiplier, and the back end
// pops no further beat until those sums are done; a B beat is written on its pop.
// After the last A element of a row the block sends dim rsp beats, one per
// cycle while rsp_stall is low, columns in order, with last set on the final one.
// Beats queue (four deep) between the front and the back; req_stall rises only
// when that queue is full. rsp_stall holds the output register and the back end
// stalls its row emission; the front keeps taking beats until the queue fills.
// csr_ready is high only while the block is idle; a csr write sets dim and
// clears the accumulators and all positions, but keeps the B store.
// Reset (synchronous) sets dim to 8, clears all counters and accumulators.
// The B store is not cleared: read only entries that were loaded.
`default_nettype none
module integer_matrix_multiply
   import imm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CFG_WIDTH-1:0] csr_data
);

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   job_type          push_job;
   job_type          head_job;
   logic             cfg_clear;
   logic [DIM_W-1:0] dim_active;
   logic             back_busy;
   logic             idle;

   assign idle = q_empty && !back_busy;

   imm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .idle        (idle),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .cfg_clear   (cfg_clear),
      .dim_active  (dim_active)
   );

   imm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   imm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (cfg_clear),
      .dim_active  (dim_active),
      .q_job       (head_job),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .busy        (back_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// File: verif/integer_matrix_multiply_test.sv
// Self-checking testbench for the integer matrix multiply block.
module integer_matrix_multiply_test;
   import imm_pkg::*;

   localparam int ITEM_GOAL     = 330;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 400;
   localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MINUS_ONE = '1;

   // Mirror of the block: B store, row sums and positions; rows land in due.
   class product_board;
      logic [CFG_WIDTH-1:0]         dim_setting;
      logic signed [DATA_WIDTH-1:0] b_entries [STORE_DEPTH];
      bit                           loaded [STORE_DEPTH];
      longint                       row_sums [MAX_DIM];
      int                           load_pos;
      int                           a_col;
      int                           a_row;
      rsp_type                      due [$];
      int                           failures = 0;

      function new();
         dim_setting = DIM_RESET;
         clear_progress();
      endfunction

      function void clear_progress();
         foreach (row_sums[j]) row_sums[j] = 0;
         load_pos = 0;
         a_col = 0;
         a_row = 0;
      endfunction

      function void set_dim(logic [CFG_WIDTH-1:0] setting);
         dim_setting = setting;
         clear_progress();
      endfunction

      function int side();
         if (dim_setting == 0) return 1;
         if (dim_setting > MAX_DIM) return MAX_DIM;
         return dim_setting;
      endfunction

      function bit store_ready(int d);
         for (int i = 0; i < d * d; i++)
            if (!loaded[i]) return 1'b0;
         return 1'b1;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void note_element(req_type beat);
         int      d;
         longint  a;
         rsp_type r;
         d = side();
         if (beat.op == OP_LOAD_B) begin
            b_entries[load_pos] = beat.element_value;
            loaded[load_pos] = 1'b1;
            load_pos++;
            if (load_pos >= d * d) load_pos = 0;
            return;
         end
         if (a_col >= d) a_col = 0;
         a = longint'(signed'(beat.element_value));
         for (int j = 0; j < d; j++)
            row_sums[j] += a * longint'(b_entries[a_col * d + j]);
         a_col++;
         if (a_col < d) return;
         // row complete: emit one result per column and clear the sums
         for (int j = 0; j < d; j++) begin
            r.product_value = row_sums[j][PRODUCT_W-1:0];
            r.row_index     = IDX_W'(a_row);
            r.col_index     = IDX_W'(j);
            r.last          = (j == d - 1);
            due.push_back(r);
            row_sums[j] = 0;
         end
         a_col = 0;
         a_row++;
         if (a_row >= d) a_row = 0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            failures++;
            return;
         end
         want = due.pop_front();
         if (got.product_value !== want.product_value) begin
            $display("%0t: product_value expected %0d actual %0d", $time,
                     want.product_value, got.product_value);
            failures++;
         end
         if (got.row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d actual %0d", $time,
                     want.row_index, got.row_index);
            failures++;
         end
         if (got.col_index !== want.col_index) begin
            $display("%0t: col_index expected %0d actual %0d", $time,
                     want.col_index, got.col_index);
            failures++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   logic pressure_go = 1'b0;
   logic long_hold = 1'b0;
   bit   no_idle = 1'b0;
   int   items_sent = 0;

   product_board board = new();

   integer_matrix_multiply dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3: return MINUS_ONE;
         default: return DATA_WIDTH'($urandom);
      endcase
   endfunction

   // Leave valid high on return; a gap before the next beat or a settle lowers it.
   task automatic send_element(input logic kind, input logic signed [DATA_WIDTH-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{op: kind, element_value: value};
      do @(posedge clock); while (req_stall);
      board.note_element(req_payload);
      items_sent++;
   endtask

   // Drain all results, then give queued beats without results time to retire.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dim(input logic [CFG_WIDTH-1:0] setting);
      csr_valid <= 1'b1;
      csr_data  <= setting;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.set_dim(setting);
   endtask

   // One setting: make sure B covers dim*dim, then stream A rows with stray B beats.
   task automatic run_phase(input logic [CFG_WIDTH-1:0] setting, input int rows,
                            input bit squeeze);
      int d;
      int extra;
      settle_block();
      write_dim(setting);
      d = board.side();
      no_idle = squeeze || ($urandom_range(0, 3) == 0);
      if (!board.store_ready(d) || $urandom_range(0, 2) == 0) begin
         extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, d) : 0;
         repeat (d * d + extra) send_element(OP_LOAD_B, pick_value());
      end
      if (rows == 0)
         rows = (d > 4) ? $urandom_range(1, 3) : $urandom_range(1, 2 * d + 1);
      if (squeeze) pressure_go <= 1'b1;
      repeat (rows * d) begin
         if ($urandom_range(0, 11) == 0) send_element(OP_LOAD_B, pick_value());
         send_element(OP_STREAM_A, pick_value());
      end
      // sometimes leave a row unfinished for the next dim write to drop
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(0, d - 1)) send_element(OP_STREAM_A, pick_value());
   endtask

   // Receiver: random stall after each beat, calm stretches, one long hold-off.
   initial begin
      int hold;
      int seen;
      bit calm;
      hold = 0;
      seen = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            board.check_result(rsp_payload);
            seen++;
            if (seen % 32 == 0) calm = ($urandom_range(0, 2) == 0);
            hold = calm ? 0 : $urandom_range(0, 14);
         end
         rsp_stall <= long_hold || hold > 0;
         if (hold > 0) hold--;
      end
   end

   initial begin
      do @(posedge clock); while (!pressure_go);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("integer_matrix_multiply_test NOT OK");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // dim 0 acts as 1: every A beat ends a row, load wraps onto entry 0
      write_dim('0);
      send_element(OP_LOAD_B, MOST_NEG);
      send_element(OP_STREAM_A, MOST_NEG);
      send_element(OP_STREAM_A, MOST_POS);
      send_element(OP_LOAD_B, MOST_POS);
      send_element(OP_STREAM_A, MINUS_ONE);
      settle_block();

      // dim 2: fifth B beat overwrites entry 0, third row wraps the row count
      write_dim(4'd2);
      send_element(OP_LOAD_B, MOST_POS);
      send_element(OP_LOAD_B, MOST_NEG);
      send_element(OP_LOAD_B, MINUS_ONE);
      send_element(OP_LOAD_B, '0);
      send_element(OP_LOAD_B, MOST_NEG);
      send_element(OP_STREAM_A, MOST_NEG);
      send_element(OP_STREAM_A, MOST_NEG);
      send_element(OP_STREAM_A, MOST_POS);
      send_element(OP_STREAM_A, 16'sd1);
      send_element(OP_STREAM_A, MINUS_ONE);
      send_element(OP_STREAM_A, '0);
      send_element(OP_STREAM_A, MOST_POS);
      settle_block();

      // dim write drops the half row; A runs on the kept store
      write_dim(4'd1);
      send_element(OP_STREAM_A, MOST_POS);

      run_phase(4'd15, 2, 1'b0);
      run_phase(4'd9, 1, 1'b0);
      run_phase(4'd8, 6, 1'b1);
      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: run_phase(CFG_WIDTH'($urandom_range(1, 4)), 0, 1'b0);
            6, 7: run_phase(CFG_WIDTH'($urandom_range(5, 8)), 0, 1'b0);
            default: run_phase(CFG_WIDTH'($urandom_range(0, 15)), 0, 1'b0);
         endcase
      end
      settle_block();

      if (board.failures == 0) begin
         $display("integer_matrix_multiply_test OK");
      end else begin
         $display("integer_matrix_multiply_test NOT OK");
      end
      $finish;
   end

endmodule
